@@ hdl/qmm_pkg.sv @@
// Shared types and constants for the quad motor mixer.
// Used by the top level, the front and back sections and the checker; depends on nothing.
`timescale 1ns / 1ps

package qmm_pkg;

    localparam int PULSE_W = 16;
    localparam int THR_W   = 7;
    localparam int TERM_W  = 8;
    localparam int INDEX_W = 2;

    // Product of throttle and span, and the offset that makes it positive.
    localparam int NUM_W   = 25;
    localparam int NUM_OFFSET = 13107200;   // 100 * Q_OFFSET
    localparam int Q_OFFSET   = 131072;

    // Reciprocal of 100, scaled by two to the DIV_SHIFT, rounded up.
    localparam int DIV_SHIFT = 31;
    localparam int REC_K     = 21474837;
    localparam int PROD_W    = 2 * NUM_W;
    localparam int QUO_W     = PROD_W - DIV_SHIFT;

    localparam int BASE_W = 20;
    localparam int MOT_W  = 24;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 8;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 16'd2000;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 16'd4000;
    localparam logic [PULSE_W-1:0] KILL_PULSE_RST = 16'd2000;

    typedef enum logic [INDEX_W-1:0] {
        REG_MIN_PULSE  = 2'd0,
        REG_MAX_PULSE  = 2'd1,
        REG_KILL_PULSE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [PULSE_W-1:0] kill_pulse;
    } cfg_t;

    // One classified item: its base width and the three corrections.
    typedef struct packed {
        logic signed [BASE_W-1:0] base;
        logic signed [TERM_W-1:0] roll_term;
        logic signed [TERM_W-1:0] pitch_term;
        logic signed [TERM_W-1:0] yaw_term;
    } mix_item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] left_front_width;
        logic [PULSE_W-1:0] right_front_width;
        logic [PULSE_W-1:0] right_back_width;
        logic [PULSE_W-1:0] left_back_width;
    } mix_result_t;

endpackage

@@ hdl/quad_motor_mixer.sv @@
// Top level of the quad motor mixer: configuration registers, the front and
// back sections, the queues between them and the flow control.
// Depends on qmm_pkg, qmm_fifo, qmm_front and qmm_back.
//
// Usage: write throttle and the roll, pitch and yaw terms with push while full
// is low; one beat is taken per cycle. Results come out in order on the four
// width ports while empty is low, and pop takes the oldest one.
// Path: a taken beat passes through two front stages, the middle queue, three
// mixing stages and the output queue to the result ports. Throughput is one
// item per cycle while pop keeps up; the multiplier stages of the front
// section and the three mixing stages are all fully pipelined.
// When the receiver stalls, the output queue (OUT_DEPTH entries) fills, the
// back section stops drawing from the middle queue, and once the front side
// holds MID_DEPTH items full rises; nothing is dropped.
// Reset clears both queues and loads min_pulse 2000, max_pulse 4000 and
// kill_pulse 2000. Registers are written with cfg_we, cfg_addr and cfg_wdata;
// write them only while no item is in flight.
`timescale 1ns / 1ps

module quad_motor_mixer #(
    parameter int MID_DEPTH = qmm_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = qmm_pkg::OUT_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [qmm_pkg::THR_W-1:0]         throttle,
    input  logic signed [qmm_pkg::TERM_W-1:0] roll_term,
    input  logic signed [qmm_pkg::TERM_W-1:0] pitch_term,
    input  logic signed [qmm_pkg::TERM_W-1:0] yaw_term,
    output logic                              empty,
    input  logic                              pop,
    output logic [qmm_pkg::PULSE_W-1:0]       left_front_width,
    output logic [qmm_pkg::PULSE_W-1:0]       right_front_width,
    output logic [qmm_pkg::PULSE_W-1:0]       right_back_width,
    output logic [qmm_pkg::PULSE_W-1:0]       left_back_width,
    input  logic                              cfg_we,
    input  logic [qmm_pkg::INDEX_W-1:0]       cfg_addr,
    input  logic [qmm_pkg::PULSE_W-1:0]       cfg_wdata
);

    import qmm_pkg::*;

    localparam int MCW = $clog2(MID_DEPTH + 1);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    cfg_t        cfg_reg;
    logic        accept;
    logic        front_valid;
    mix_item_t   front_item;
    mix_item_t   mid_item;
    logic        mid_empty;
    logic        mid_pop;
    logic        back_valid;
    mix_result_t back_result;
    mix_result_t out_result;
    logic        out_pop;

    // Occupancy of each section counts items in its pipeline plus its queue.
    logic [MCW-1:0] front_occ_reg, front_occ_next;
    logic [OCW-1:0] back_occ_reg, back_occ_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_pulse  <= MIN_PULSE_RST;
            cfg_reg.max_pulse  <= MAX_PULSE_RST;
            cfg_reg.kill_pulse <= KILL_PULSE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_PULSE:  cfg_reg.min_pulse  <= cfg_wdata;
                REG_MAX_PULSE:  cfg_reg.max_pulse  <= cfg_wdata;
                REG_KILL_PULSE: cfg_reg.kill_pulse <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign full    = (front_occ_reg == MCW'(MID_DEPTH));
    assign accept  = push && !full;
    assign mid_pop = !mid_empty && (back_occ_reg < OCW'(OUT_DEPTH));
    assign out_pop = pop && !empty;

    always_comb
    begin
        front_occ_next = front_occ_reg;
        if (accept && !mid_pop)
        begin
            front_occ_next = front_occ_reg + 1'b1;
        end
        else if (!accept && mid_pop)
        begin
            front_occ_next = front_occ_reg - 1'b1;
        end

        back_occ_next = back_occ_reg;
        if (mid_pop && !out_pop)
        begin
            back_occ_next = back_occ_reg + 1'b1;
        end
        else if (!mid_pop && out_pop)
        begin
            back_occ_next = back_occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_occ_reg <= '0;
            back_occ_reg  <= '0;
        end
        else
        begin
            front_occ_reg <= front_occ_next;
            back_occ_reg  <= back_occ_next;
        end
    end

    qmm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (accept),
        .throttle   (throttle),
        .roll_term  (roll_term),
        .pitch_term (pitch_term),
        .yaw_term   (yaw_term),
        .out_valid  (front_valid),
        .out_item   (front_item)
    );

    qmm_fifo #(
        .WIDTH ($bits(mix_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .din   (front_item),
        .pop   (mid_pop),
        .dout  (mid_item),
        .empty (mid_empty)
    );

    qmm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (mid_pop),
        .in_item    (mid_item),
        .out_valid  (back_valid),
        .out_result (back_result)
    );

    qmm_fifo #(
        .WIDTH ($bits(mix_result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_valid),
        .din   (back_result),
        .pop   (out_pop),
        .dout  (out_result),
        .empty (empty)
    );

    assign left_front_width  = out_result.left_front_width;
    assign right_front_width = out_result.right_front_width;
    assign right_back_width  = out_result.right_back_width;
    assign left_back_width   = out_result.left_back_width;

endmodule

@@ hdl/qmm_fifo.sv @@
// Small register FIFO used between the mixer sections and at its output.
// Depends on nothing; the head entry is shown while empty is low.
`timescale 1ns / 1ps

module qmm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_pop;

    assign empty  = (count_reg == '0);
    assign dout   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ hdl/qmm_front.sv @@
// Front section of the mixer: scales the throttle into a base pulse width.
// Depends on qmm_pkg; a two-stage pipeline that never stalls.
`timescale 1ns / 1ps

module qmm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qmm_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    input  logic [qmm_pkg::THR_W-1:0]     throttle,
    input  logic signed [qmm_pkg::TERM_W-1:0] roll_term,
    input  logic signed [qmm_pkg::TERM_W-1:0] pitch_term,
    input  logic signed [qmm_pkg::TERM_W-1:0] yaw_term,
    output logic                          out_valid,
    output qmm_pkg::mix_item_t            out_item
);

    import qmm_pkg::*;

    logic signed [THR_W:0]     thr_c;
    logic signed [PULSE_W:0]   span_c;
    logic signed [NUM_W-1:0]   num_c;

    logic                      s1_valid_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic                      zero_reg;
    logic signed [TERM_W-1:0]  roll_reg, pitch_reg, yaw_reg;

    logic [NUM_W-1:0]          x_c;
    logic [PROD_W-1:0]         prod_c;
    logic [QUO_W-1:0]          quo_c;
    logic signed [BASE_W-1:0]  base_c;

    logic                      s2_valid_reg;
    mix_item_t                 item_reg;

    // Stage one: throttle times (max - min), exact in 25 signed bits.
    always_comb
    begin
        thr_c  = $signed({1'b0, throttle});
        span_c = $signed({1'b0, cfg.max_pulse}) - $signed({1'b0, cfg.min_pulse});
        num_c  = NUM_W'(thr_c) * NUM_W'(span_c);
    end

    // Stage two: the offset keeps the dividend positive, so the reciprocal
    // product gives the floor of the quotient directly, also for a negative span.
    always_comb
    begin
        x_c    = $unsigned(num_reg) + NUM_W'(NUM_OFFSET);
        prod_c = PROD_W'(x_c) * PROD_W'(REC_K);
        quo_c  = prod_c[PROD_W-1:DIV_SHIFT];
        if (zero_reg)
        begin
            base_c = $signed({{(BASE_W-PULSE_W){1'b0}}, cfg.kill_pulse});
        end
        else
        begin
            base_c = $signed({{(BASE_W-QUO_W){1'b0}}, quo_c})
                   - $signed(BASE_W'(Q_OFFSET))
                   + $signed({{(BASE_W-PULSE_W){1'b0}}, cfg.min_pulse});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg             <= num_c;
        zero_reg            <= (throttle == '0);
        roll_reg            <= roll_term;
        pitch_reg           <= pitch_term;
        yaw_reg             <= yaw_term;
        item_reg.base       <= base_c;
        item_reg.roll_term  <= roll_reg;
        item_reg.pitch_term <= pitch_reg;
        item_reg.yaw_term   <= yaw_reg;
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = item_reg;

endmodule

@@ hdl/qmm_back.sv @@
// Back section of the mixer: roll, pitch and yaw stages with clamp and
// transfer, then saturation to 16 bits. Depends on qmm_pkg.
`timescale 1ns / 1ps

module qmm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qmm_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    input  qmm_pkg::mix_item_t   in_item,
    output logic                 out_valid,
    output qmm_pkg::mix_result_t out_result
);

    import qmm_pkg::*;

    typedef logic signed [MOT_W-1:0] motor_t;

    typedef struct packed {
        logic signed [MOT_W-1:0] v;
        logic signed [MOT_W-1:0] p;
    } pair_t;

    // Clamp the checked motor and push the excess onto its partner.
    function automatic pair_t check_pair(motor_t v, motor_t p, motor_t lo, motor_t hi);
        pair_t r;
        r.v = v;
        r.p = p;
        if (v > hi)
        begin
            r.p = p - (v - hi);
            r.v = hi;
            if (r.p < lo)
            begin
                r.p = lo;
            end
        end
        else if (v < lo)
        begin
            r.p = p + (lo - v);
            r.v = lo;
            if (r.p > hi)
            begin
                r.p = hi;
            end
        end
        return r;
    endfunction

    function automatic logic [PULSE_W-1:0] sat16(motor_t v);
        logic [PULSE_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed(MOT_W'(17'h0FFFF)))
        begin
            r = '1;
        end
        else
        begin
            r = v[PULSE_W-1:0];
        end
        return r;
    endfunction

    motor_t lo_c, hi_c;
    motor_t base_c, roll_c, pitch_c, yaw_c;
    motor_t ra [4];
    motor_t pa [4];
    motor_t ya [4];
    pair_t  rc0, rc1, pc0, pc1, yc0, yc1;

    motor_t roll_m_reg  [4];
    motor_t pitch_m_reg [4];
    motor_t yaw_m_reg   [4];
    logic signed [TERM_W-1:0] r_pitch_reg, r_yaw_reg, p_yaw_reg;
    logic   roll_valid_reg, pitch_valid_reg, yaw_valid_reg;

    assign lo_c = $signed({{(MOT_W-PULSE_W){1'b0}}, cfg.min_pulse});
    assign hi_c = $signed({{(MOT_W-PULSE_W){1'b0}}, cfg.max_pulse});

    // Roll: M1+ M2- M3- M4+, then M1 onto M3 and M4 onto M2.
    always_comb
    begin
        base_c = MOT_W'(in_item.base);
        roll_c = MOT_W'(in_item.roll_term);
        ra[0]  = base_c + roll_c;
        ra[1]  = base_c - roll_c;
        ra[2]  = base_c - roll_c;
        ra[3]  = base_c + roll_c;
        rc0    = check_pair(ra[0], ra[2], lo_c, hi_c);
        rc1    = check_pair(ra[3], ra[1], lo_c, hi_c);
    end

    // Pitch: M1+ M2+ M3- M4-, then M1 onto M4 and M2 onto M3.
    always_comb
    begin
        pitch_c = MOT_W'(r_pitch_reg);
        pa[0]   = roll_m_reg[0] + pitch_c;
        pa[1]   = roll_m_reg[1] + pitch_c;
        pa[2]   = roll_m_reg[2] - pitch_c;
        pa[3]   = roll_m_reg[3] - pitch_c;
        pc0     = check_pair(pa[0], pa[3], lo_c, hi_c);
        pc1     = check_pair(pa[1], pa[2], lo_c, hi_c);
    end

    // Yaw: M1+ M2- M3+ M4-, then M1 onto M2 and M3 onto M4.
    always_comb
    begin
        yaw_c = MOT_W'(p_yaw_reg);
        ya[0] = pitch_m_reg[0] + yaw_c;
        ya[1] = pitch_m_reg[1] - yaw_c;
        ya[2] = pitch_m_reg[2] + yaw_c;
        ya[3] = pitch_m_reg[3] - yaw_c;
        yc0   = check_pair(ya[0], ya[1], lo_c, hi_c);
        yc1   = check_pair(ya[2], ya[3], lo_c, hi_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_valid_reg  <= 1'b0;
            pitch_valid_reg <= 1'b0;
            yaw_valid_reg   <= 1'b0;
        end
        else
        begin
            roll_valid_reg  <= in_valid;
            pitch_valid_reg <= roll_valid_reg;
            yaw_valid_reg   <= pitch_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        roll_m_reg[0]  <= rc0.v;
        roll_m_reg[2]  <= rc0.p;
        roll_m_reg[3]  <= rc1.v;
        roll_m_reg[1]  <= rc1.p;
        r_pitch_reg    <= in_item.pitch_term;
        r_yaw_reg      <= in_item.yaw_term;

        pitch_m_reg[0] <= pc0.v;
        pitch_m_reg[3] <= pc0.p;
        pitch_m_reg[1] <= pc1.v;
        pitch_m_reg[2] <= pc1.p;
        p_yaw_reg      <= r_yaw_reg;

        yaw_m_reg[0]   <= yc0.v;
        yaw_m_reg[1]   <= yc0.p;
        yaw_m_reg[2]   <= yc1.v;
        yaw_m_reg[3]   <= yc1.p;
    end

    always_comb
    begin
        out_result.left_front_width  = sat16(yaw_m_reg[0]);
        out_result.right_front_width = sat16(yaw_m_reg[1]);
        out_result.right_back_width  = sat16(yaw_m_reg[2]);
        out_result.left_back_width   = sat16(yaw_m_reg[3]);
    end

    assign out_valid = yaw_valid_reg;

endmodule

@@ bench/qmm_checker.sv @@
// Checker for the quad motor mixer: keeps its own copy of the pulse registers,
// predicts the four motor widths of every accepted beat and compares them in order.
// Depends on qmm_pkg only.
`timescale 1ns / 1ps

module qmm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic [qmm_pkg::THR_W-1:0]         throttle,
    input  logic signed [qmm_pkg::TERM_W-1:0] roll_term,
    input  logic signed [qmm_pkg::TERM_W-1:0] pitch_term,
    input  logic signed [qmm_pkg::TERM_W-1:0] yaw_term,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [qmm_pkg::PULSE_W-1:0]       left_front_width,
    input  logic [qmm_pkg::PULSE_W-1:0]       right_front_width,
    input  logic [qmm_pkg::PULSE_W-1:0]       right_back_width,
    input  logic [qmm_pkg::PULSE_W-1:0]       left_back_width,
    input  logic                              cfg_we,
    input  logic [qmm_pkg::INDEX_W-1:0]       cfg_addr,
    input  logic [qmm_pkg::PULSE_W-1:0]       cfg_wdata,
    output int                                errors,
    output int                                outstanding,
    output int                                checked
);

    import qmm_pkg::*;

    cfg_t        pulse_cfg;
    mix_result_t widths_due [$];

    // Clamp motor v to the pulse window and push the excess onto partner p.
    function automatic void settle_pair(inout int v, inout int p);
        int lo;
        int hi;
        lo = int'(pulse_cfg.min_pulse);
        hi = int'(pulse_cfg.max_pulse);
        if (v > hi)
        begin
            p = p - (v - hi);
            v = hi;
            if (p < lo)
                p = lo;
        end
        else if (v < lo)
        begin
            p = p + (lo - v);
            v = lo;
            if (p > hi)
                p = hi;
        end
    endfunction

    function automatic logic [PULSE_W-1:0] sat_width(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return 16'hFFFF;
        return v[PULSE_W-1:0];
    endfunction

    function automatic mix_result_t mix_widths(logic [THR_W-1:0] thr,
                                               logic signed [TERM_W-1:0] roll,
                                               logic signed [TERM_W-1:0] pitch,
                                               logic signed [TERM_W-1:0] yaw);
        int          lo;
        int          hi;
        int          pct;
        int          num;
        int          quo;
        int          rr;
        int          pp;
        int          yy;
        int          m1;
        int          m2;
        int          m3;
        int          m4;
        mix_result_t res;
        lo  = int'(pulse_cfg.min_pulse);
        hi  = int'(pulse_cfg.max_pulse);
        pct = int'(thr);
        rr  = int'(roll);
        pp  = int'(pitch);
        yy  = int'(yaw);
        if (pct == 0)
            m1 = int'(pulse_cfg.kill_pulse);
        else
        begin
            num = pct * (hi - lo);
            quo = num / 100;
            // Integer division truncates; the span may be negative and needs a floor.
            if (num < 0 && quo * 100 != num)
                quo = quo - 1;
            m1 = quo + lo;
        end
        m2 = m1;
        m3 = m1;
        m4 = m1;

        m1 += rr; m2 -= rr; m3 -= rr; m4 += rr;
        settle_pair(m1, m3);
        settle_pair(m4, m2);

        m1 += pp; m2 += pp; m3 -= pp; m4 -= pp;
        settle_pair(m1, m4);
        settle_pair(m2, m3);

        m1 += yy; m2 -= yy; m3 += yy; m4 -= yy;
        settle_pair(m1, m2);
        settle_pair(m3, m4);

        res.left_front_width  = sat_width(m1);
        res.right_front_width = sat_width(m2);
        res.right_back_width  = sat_width(m3);
        res.left_back_width   = sat_width(m4);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mix_result_t want;
        mix_result_t got;
        if (!rst_n)
        begin
            pulse_cfg.min_pulse  = MIN_PULSE_RST;
            pulse_cfg.max_pulse  = MAX_PULSE_RST;
            pulse_cfg.kill_pulse = KILL_PULSE_RST;
            widths_due.delete();
            errors      <= 0;
            outstanding <= 0;
            checked     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_addr))
                    REG_MIN_PULSE:  pulse_cfg.min_pulse  = cfg_wdata;
                    REG_MAX_PULSE:  pulse_cfg.max_pulse  = cfg_wdata;
                    REG_KILL_PULSE: pulse_cfg.kill_pulse = cfg_wdata;
                    default: ;
                endcase
            end

            // Check the outgoing beat before queueing a new one; no beat passes
            // through the block in the cycle it enters.
            if (pop && !empty)
            begin
                got.left_front_width  = left_front_width;
                got.right_front_width = right_front_width;
                got.right_back_width  = right_back_width;
                got.left_back_width   = left_back_width;
                if (widths_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("qmm_checker: unexpected result %0d %0d %0d %0d",
                                 got.left_front_width, got.right_front_width,
                                 got.right_back_width, got.left_back_width);
                    errors <= errors + 1;
                end
                else
                begin
                    want = widths_due.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display("qmm_checker: result %0d exp %0d %0d %0d %0d",
                                     checked, want.left_front_width,
                                     want.right_front_width, want.right_back_width,
                                     want.left_back_width,
                                     " got %0d %0d %0d %0d",
                                     got.left_front_width, got.right_front_width,
                                     got.right_back_width, got.left_back_width);
                        errors <= errors + 1;
                    end
                    checked <= checked + 1;
                end
            end

            if (push && !full)
                widths_due.push_back(mix_widths(throttle, roll_term, pitch_term, yaw_term));

            outstanding <= widths_due.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the quad motor mixer: clock, reset, beat stimulus under
// several pulse register settings, receiver stalls and the verdict.
// Depends on qmm_pkg, quad_motor_mixer and qmm_checker.
`timescale 1ns / 1ps

module tb_top;

    import qmm_pkg::*;

    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;
    localparam int PHASE_BEATS = 140;
    localparam int RAND_PHASES = 12;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    logic [THR_W-1:0]          throttle = '0;
    logic signed [TERM_W-1:0]  roll_term = '0;
    logic signed [TERM_W-1:0]  pitch_term = '0;
    logic signed [TERM_W-1:0]  yaw_term = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [PULSE_W-1:0]        left_front_width;
    logic [PULSE_W-1:0]        right_front_width;
    logic [PULSE_W-1:0]        right_back_width;
    logic [PULSE_W-1:0]        left_back_width;
    logic                      cfg_we = 1'b0;
    logic [INDEX_W-1:0]        cfg_addr = '0;
    logic [PULSE_W-1:0]        cfg_wdata = '0;

    int errors;
    int outstanding;
    int checked;

    int stuck_cycles = 0;
    int beats_sent = 0;
    int settings_used = 1;
    int holds_asked = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    always #5 clk = ~clk;

    quad_motor_mixer DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .throttle          (throttle),
        .roll_term         (roll_term),
        .pitch_term        (pitch_term),
        .yaw_term          (yaw_term),
        .empty             (empty),
        .pop               (pop),
        .left_front_width  (left_front_width),
        .right_front_width (right_front_width),
        .right_back_width  (right_back_width),
        .left_back_width   (left_back_width),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata)
    );

    qmm_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .throttle          (throttle),
        .roll_term         (roll_term),
        .pitch_term        (pitch_term),
        .yaw_term          (yaw_term),
        .empty             (empty),
        .pop               (pop),
        .left_front_width  (left_front_width),
        .right_front_width (right_front_width),
        .right_back_width  (right_back_width),
        .left_back_width   (left_back_width),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .errors            (errors),
        .outstanding       (outstanding),
        .checked           (checked)
    );

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 0;
        else if (pick < 18)
            return $urandom_range(1, 4);
        return $urandom_range(10, 50);
    endfunction

    function automatic int pick_throttle();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 100;
            2:       return $urandom_range(101, 127);
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    function automatic int pick_term();
        case ($urandom_range(0, 7))
            0:       return -128;
            1:       return 127;
            2:       return $urandom_range(0, 1) ? 100 : -100;
            3:       return $urandom_range(0, 6) - 3;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic push_beat(input int thr, input int roll, input int pitch, input int yaw);
        push       <= 1'b1;
        throttle   <= thr[THR_W-1:0];
        roll_term  <= roll[TERM_W-1:0];
        pitch_term <= pitch[TERM_W-1:0];
        yaw_term   <= yaw[TERM_W-1:0];
        @(posedge clk);
        while (full)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic pause_sender();
        int gap;
        gap = tx_steady ? 0 : idle_span();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Registers change only with nothing in flight.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_pulses(input logic [PULSE_W-1:0] lo,
                                input logic [PULSE_W-1:0] hi,
                                input logic [PULSE_W-1:0] kill);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MIN_PULSE;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_addr  <= REG_MAX_PULSE;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_addr  <= REG_KILL_PULSE;
        cfg_wdata <= kill;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Receiver: random pop stalls, steady stretches, and one long hold-off on request.
    initial
    begin
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_done)
            begin
                holds_done = holds_asked;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (rx_steady || $urandom_range(0, 9) < 6)
                pop <= 1'b1;
            else
            begin
                pop <= 1'b0;
                stall_left = idle_span();
            end
        end
    end

    // Watchdog: any accepted beat, popped result or register write counts as progress.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_we)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb_top: watchdog expired, %0d results still due", outstanding);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        int dir_thr   [20] = '{0, 100, 127, 1, 50, 50, 50, 50, 50, 50,
                               100, 0, 100, 0, 127, 1, 99, 2, 127, 0};
        int dir_roll  [20] = '{0, 0, 0, 0, 127, -128, 0, 0, 0, 0,
                               100, -100, -128, 127, 127, -128, 100, -100, -1, 1};
        int dir_pitch [20] = '{0, 0, 0, 0, 0, 0, 127, -128, 0, 0,
                               100, -100, -128, 127, -128, 127, -100, 100, -1, 1};
        int dir_yaw   [20] = '{0, 0, 0, 0, 0, 0, 0, 0, 127, -128,
                               100, -100, -128, 127, 127, -128, 100, -100, -1, 1};
        int fix_lo    [8]  = '{0, 65535, 1500, 3000, 0, 65535, 100, 2000};
        int fix_hi    [8]  = '{65535, 0, 1600, 3000, 0, 65535, 60000, 4000};
        int fix_kill  [8]  = '{0, 65535, 1550, 0, 65535, 65535, 30, 2000};
        int lo;
        int hi;
        int kill;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners under the reset register values.
        for (int i = 0; i < 20; i++)
        begin
            push_beat(dir_thr[i], dir_roll[i], dir_pitch[i], dir_yaw[i]);
            pause_sender();
        end
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph < 8)
            begin
                lo   = fix_lo[ph];
                hi   = fix_hi[ph];
                kill = fix_kill[ph];
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                lo   = $urandom_range(0, 65535);
                hi   = $urandom_range(0, 65535);
                kill = $urandom_range(0, 65535);
            end
            else
            begin
                // A narrow window around typical widths keeps the clamps busy.
                lo   = $urandom_range(500, 3000);
                hi   = lo + $urandom_range(0, 2500);
                kill = $urandom_range(0, 1) ? lo : $urandom_range(0, 65535);
            end
            write_pulses(lo[PULSE_W-1:0], hi[PULSE_W-1:0], kill[PULSE_W-1:0]);

            tx_steady = (ph % 4 == 1) || (ph == 3);
            rx_steady = (ph % 4 == 2);
            // Stall the receiver for a long stretch while beats keep coming.
            if (ph == 3)
                holds_asked++;

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                push_beat(pick_throttle(), pick_term(), pick_term(), pick_term());
                pause_sender();
            end
            drain();
        end

        $display("tb_top: %0d beats sent under %0d pulse settings, %0d results checked",
                 beats_sent, settings_used, checked);
        $display("tb_top: covered kill width, throttle over 100, inverted and zero spans, saturation");
        if (errors == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
